[hdl/skf_pkg.sv]
// ----------------------------------------------------------------------------
// skf_pkg
// Types, constants and microcode program of the scalar Kalman filter core.
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int COV_W       = 32;
    localparam int NOISE_W     = 16;
    localparam int NOISE_SHIFT = 8;
    localparam int PC_W        = 4;
    localparam int CFG_IDX_W   = 2;

    localparam logic [NOISE_W-1:0] Q_RESET     = 16'd1280;
    localparam logic [NOISE_W-1:0] R_RESET     = 16'd2560;
    localparam logic [31:0]        LIMIT_RESET = 32'd256000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROCESS_NOISE = 2'd0,
        CFG_MEASURE_NOISE = 2'd1,
        CFG_SAMPLE_LIMIT  = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        OP_WAIT,
        OP_PMID,
        OP_DEN,
        OP_DIV,
        OP_GAIN,
        OP_MULX,
        OP_UPDX,
        OP_UPDP,
        OP_CLAMP
    } op_t;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_IDLE,
        COND_CLAMP,
        COND_CNT
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
        logic            emit;
    } ctrl_t;

    typedef struct packed {
        logic clamp;
        logic cnt_nz;
        logic out_full;
    } stat_t;

    localparam logic [PC_W-1:0] PC_WAIT  = 4'd0;
    localparam logic [PC_W-1:0] PC_PMID  = 4'd1;
    localparam logic [PC_W-1:0] PC_DEN   = 4'd2;
    localparam logic [PC_W-1:0] PC_DIV   = 4'd3;
    localparam logic [PC_W-1:0] PC_GAIN  = 4'd4;
    localparam logic [PC_W-1:0] PC_MULX  = 4'd5;
    localparam logic [PC_W-1:0] PC_UPDX  = 4'd6;
    localparam logic [PC_W-1:0] PC_UPDP  = 4'd7;
    localparam logic [PC_W-1:0] PC_CLAMP = 4'd8;

    function automatic ctrl_t skf_rom(input logic [PC_W-1:0] addr);
        ctrl_t w;
        case (addr)
            PC_WAIT:  w = '{OP_WAIT,  COND_IDLE,   PC_WAIT,  1'b0};
            PC_PMID:  w = '{OP_PMID,  COND_CLAMP,  PC_CLAMP, 1'b0};
            PC_DEN:   w = '{OP_DEN,   COND_NONE,   PC_WAIT,  1'b0};
            PC_DIV:   w = '{OP_DIV,   COND_CNT,    PC_DIV,   1'b0};
            PC_GAIN:  w = '{OP_GAIN,  COND_NONE,   PC_WAIT,  1'b0};
            PC_MULX:  w = '{OP_MULX,  COND_NONE,   PC_WAIT,  1'b0};
            PC_UPDX:  w = '{OP_UPDX,  COND_NONE,   PC_WAIT,  1'b0};
            PC_UPDP:  w = '{OP_UPDP,  COND_ALWAYS, PC_WAIT,  1'b1};
            PC_CLAMP: w = '{OP_CLAMP, COND_ALWAYS, PC_WAIT,  1'b1};
            default:  w = '{OP_WAIT,  COND_ALWAYS, PC_WAIT,  1'b0};
        endcase
        return w;
    endfunction

endpackage

[hdl/skf_seq.sv]
// ----------------------------------------------------------------------------
// skf_seq
// Microcode sequencer: step counter, program lookup and conditional jumps.
// ----------------------------------------------------------------------------
module skf_seq
    import skf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  stat_t stat,
    output ctrl_t ctrl,
    output logic  run
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    always_comb
    begin
        ctrl = skf_rom(pc_reg);
        run  = !(ctrl.emit && stat.out_full);
        case (ctrl.cond)
            COND_NONE:   take = 1'b0;
            COND_ALWAYS: take = 1'b1;
            COND_IDLE:   take = !in_valid;
            COND_CLAMP:  take = stat.clamp;
            COND_CNT:    take = stat.cnt_nz;
            default:     take = 1'b0;
        endcase
        if (!run)
        begin
            pc_next = pc_reg;
        end
        else if (take)
        begin
            pc_next = ctrl.target;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

endmodule

[hdl/skf_dp.sv]
// ----------------------------------------------------------------------------
// skf_dp
// Filter datapath: state, restoring divider step, shared multiplier, output
// register.
// ----------------------------------------------------------------------------
module skf_dp
    import skf_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = 20,
    parameter int GAIN_FRAC_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctrl_t                   ctrl,
    input  logic                    run,
    input  logic                    in_valid,
    input  logic [SAMPLE_WIDTH-1:0] measurement,
    input  logic [NOISE_W-1:0]      q_cfg,
    input  logic [NOISE_W-1:0]      r_cfg,
    input  logic [SAMPLE_WIDTH-1:0] limit_cfg,
    input  logic                    out_ready,
    output logic                    out_valid,
    output logic [SAMPLE_WIDTH-1:0] estimate,
    output logic                    clamped,
    output stat_t                   stat
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int G     = GAIN_FRAC_BITS;
    localparam int PW    = G + 1 + COV_W;
    localparam int CNT_W = $clog2(G + 1);

    localparam logic [G:0]       ONE_G = {1'b1, {G{1'b0}}};
    localparam logic [G:0]       MASK_G = ONE_G - 1'b1;
    localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(G);

    logic [SW-1:0]      z_reg;
    logic [SW-1:0]      x_reg;
    logic [COV_W-1:0]   p_reg;
    logic [COV_W-1:0]   pmid_reg;
    logic [COV_W:0]     den_reg;
    logic [COV_W+1:0]   rem_reg;
    logic [G:0]         quot_reg;
    logic [G-1:0]       gain_reg;
    logic [SW-1:0]      diff_reg;
    logic               neg_reg;
    logic [PW-1:0]      prod_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               out_valid_reg;
    logic [SW-1:0]      est_out_reg;
    logic               clamped_reg;

    logic [COV_W:0]     pmid_sum;
    logic [COV_W-1:0]   pmid_next;
    logic [COV_W:0]     den_next;
    logic               div_ge;
    logic [COV_W+1:0]   rem_sub;
    logic [G-1:0]       gain_next;
    logic [G:0]         mul_a;
    logic [COV_W-1:0]   mul_b;
    logic [PW-1:0]      prod_adj;
    logic [SW-1:0]      corr;
    logic [SW-1:0]      x_next;

    always_comb
    begin
        pmid_sum  = {1'b0, p_reg} + (COV_W + 1)'({q_cfg, {NOISE_SHIFT{1'b0}}});
        pmid_next = pmid_sum[COV_W] ? {COV_W{1'b1}} : pmid_sum[COV_W-1:0];
        den_next  = {1'b0, pmid_reg} + (COV_W + 1)'({r_cfg, {NOISE_SHIFT{1'b0}}});

        div_ge  = rem_reg >= {1'b0, den_reg};
        rem_sub = div_ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;

        if (den_reg == '0)
        begin
            gain_next = '0;
        end
        else if (quot_reg[G])
        begin
            gain_next = '1;
        end
        else
        begin
            gain_next = quot_reg[G-1:0];
        end

        if (ctrl.op == OP_MULX)
        begin
            mul_a = {1'b0, gain_reg};
            mul_b = COV_W'(diff_reg);
        end
        else
        begin
            mul_a = ONE_G - {1'b0, gain_reg};
            mul_b = pmid_reg;
        end

        prod_adj = prod_reg + (neg_reg ? PW'(MASK_G) : '0);
        corr     = prod_adj[G +: SW];
        x_next   = neg_reg ? (x_reg - corr) : (x_reg + corr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg         <= '0;
            p_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.emit && run)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (ctrl.op)
                OP_UPDX:
                begin
                    x_reg <= x_next;
                end
                OP_UPDP:
                begin
                    if (run)
                    begin
                        p_reg <= prod_reg[G +: COV_W];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            OP_WAIT:
            begin
                if (in_valid)
                begin
                    z_reg <= measurement;
                end
            end
            OP_PMID:
            begin
                pmid_reg <= pmid_next;
            end
            OP_DEN:
            begin
                den_reg <= den_next;
                rem_reg <= {2'b00, pmid_reg};
                cnt_reg <= CNT_INIT;
            end
            OP_DIV:
            begin
                rem_reg  <= {rem_sub[COV_W:0], 1'b0};
                quot_reg <= {quot_reg[G-1:0], div_ge};
                cnt_reg  <= cnt_reg - 1'b1;
            end
            OP_GAIN:
            begin
                gain_reg <= gain_next;
                neg_reg  <= z_reg < x_reg;
                diff_reg <= (z_reg < x_reg) ? (x_reg - z_reg) : (z_reg - x_reg);
            end
            OP_MULX, OP_UPDX:
            begin
                prod_reg <= mul_a * mul_b;
            end
            OP_UPDP:
            begin
                if (run)
                begin
                    est_out_reg <= x_reg;
                    clamped_reg <= 1'b0;
                end
            end
            OP_CLAMP:
            begin
                if (run)
                begin
                    est_out_reg <= limit_cfg;
                    clamped_reg <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign stat.clamp    = z_reg > limit_cfg;
    assign stat.cnt_nz   = cnt_reg != '0;
    assign stat.out_full = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign estimate  = est_out_reg;
    assign clamped   = clamped_reg;

endmodule

[hdl/scalar_kalman_filter_core.sv]
// ----------------------------------------------------------------------------
// scalar_kalman_filter_core
// One-dimensional Kalman filter for distance samples, microcode controlled.
// ----------------------------------------------------------------------------
// Each accepted measurement gives one result. A measurement above
// sample_limit returns the limit with clamped set, leaving the state alone;
// the result register then loads from the clamp step that follows the
// prediction step. Otherwise the item goes through the steps PMID, DEN,
// DIV, GAIN, MULX, UPDX and UPDP: the gain divider produces one quotient
// bit per cycle, GAIN_FRAC_BITS + 1 in all, and the multiplies share one
// registered multiplier. One item is in flight at a time; a finished result
// waits in the output register while the next item is taken, and the next
// result step stalls until it leaves. Configuration is written through
// cfg_we/cfg_index/cfg_data; the user must write it only while the block
// is idle, and the block itself does not enforce this.
module scalar_kalman_filter_core
    import skf_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = 20,
    parameter int GAIN_FRAC_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [(SAMPLE_WIDTH > NOISE_W ? SAMPLE_WIDTH : NOISE_W)-1:0] cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [SAMPLE_WIDTH-1:0] measurement,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [SAMPLE_WIDTH-1:0] estimate,
    output logic                    clamped
);

    logic [NOISE_W-1:0]      q_reg;
    logic [NOISE_W-1:0]      r_reg;
    logic [SAMPLE_WIDTH-1:0] limit_reg;
    ctrl_t                   ctrl;
    stat_t                   stat;
    logic                    run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg     <= Q_RESET;
            r_reg     <= R_RESET;
            limit_reg <= LIMIT_RESET[SAMPLE_WIDTH-1:0];
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PROCESS_NOISE: q_reg     <= cfg_data[NOISE_W-1:0];
                CFG_MEASURE_NOISE: r_reg     <= cfg_data[NOISE_W-1:0];
                CFG_SAMPLE_LIMIT:  limit_reg <= cfg_data[SAMPLE_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    skf_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .ctrl     (ctrl),
        .run      (run)
    );

    skf_dp #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .run         (run),
        .in_valid    (in_valid),
        .measurement (measurement),
        .q_cfg       (q_reg),
        .r_cfg       (r_reg),
        .limit_cfg   (limit_reg),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .estimate    (estimate),
        .clamped     (clamped),
        .stat        (stat)
    );

    assign in_ready = ctrl.op == OP_WAIT;

`ifndef SYNTH
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while one is in flight");

    a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clamped |-> estimate == limit_reg)
        else $error("bypassed result differs from limit");

    a_emit_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit && out_valid && !out_ready |=> ctrl.emit && out_valid)
        else $error("result step advanced over a pending result");
`endif

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for scalar_kalman_filter_core.
// ----------------------------------------------------------------------------
// The bench keeps its own fixed-point copy of the filter and predicts each
// estimate and clamp flag as samples are accepted. A scoreboard queue is
// compared with every result that leaves the core. Directed runs cover the
// reset settings, the limit boundary, zero measurement noise and extreme
// noise settings. Random runs follow with several noise and limit settings,
// and the sender and receiver idle at different rates.
// ----------------------------------------------------------------------------
module tb
    import skf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          SAMPLE_W     = 20;
    localparam int          GAIN_FRAC    = 16;
    localparam logic [63:0] GAIN_ONE     = 64'd1 << GAIN_FRAC;
    localparam logic [63:0] COV_SAT      = 64'hFFFF_FFFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int          BLOCK_ITEMS  = 50;
    localparam int          SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [SAMPLE_W-1:0] estimate;
        logic                clamped;
    } filter_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_PROCESS_NOISE;
    logic [SAMPLE_W-1:0] cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [SAMPLE_W-1:0] measurement = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [SAMPLE_W-1:0] estimate;
    logic                clamped;

    // filter model state and its copy of the registers
    logic [SAMPLE_W-1:0] kf_est   = '0;
    logic [COV_W-1:0]    kf_cov   = '0;
    logic [NOISE_W-1:0]  kf_q     = Q_RESET;
    logic [NOISE_W-1:0]  kf_r     = R_RESET;
    logic [SAMPLE_W-1:0] kf_limit = LIMIT_RESET[SAMPLE_W-1:0];

    filter_result_t expected_results[$];
    filter_result_t result_want;
    int             fail_count = 0;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;

    scalar_kalman_filter_core #(
        .SAMPLE_WIDTH   (SAMPLE_W),
        .GAIN_FRAC_BITS (GAIN_FRAC)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .measurement (measurement),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .estimate    (estimate),
        .clamped     (clamped)
    );

    always #1 clk = ~clk;

    initial
    begin
        #2ms;
        $display("tb: FAIL");
        $finish;
    end

    task automatic kalman_predict(input logic [SAMPLE_W-1:0] z);
        logic [63:0]    p_mid;
        logic [63:0]    den;
        logic [63:0]    gain;
        logic [63:0]    prod;
        logic [63:0]    corr;
        logic [63:0]    x;
        logic [63:0]    zz;
        logic [63:0]    p_new;
        filter_result_t res;
        if (z > kf_limit)
        begin
            res.estimate = kf_limit;
            res.clamped  = 1'b1;
        end
        else
        begin
            p_mid = {32'd0, kf_cov} + ({48'd0, kf_q} << NOISE_SHIFT);
            if (p_mid > COV_SAT)
                p_mid = COV_SAT;
            den = p_mid + ({48'd0, kf_r} << NOISE_SHIFT);
            if (den == 64'd0)
                gain = 64'd0;
            else
            begin
                gain = (p_mid << GAIN_FRAC) / den;
                if (gain > GAIN_ONE - 64'd1)
                    gain = GAIN_ONE - 64'd1;
            end
            x  = {44'd0, kf_est};
            zz = {44'd0, z};
            if (zz >= x)
            begin
                prod = gain * (zz - x);
                corr = prod >> GAIN_FRAC;
                x    = x + corr;
            end
            else
            begin
                // correction rounds toward minus infinity
                prod = gain * (x - zz);
                corr = (prod + GAIN_ONE - 64'd1) >> GAIN_FRAC;
                x    = x - corr;
            end
            p_new  = ((GAIN_ONE - gain) * p_mid) >> GAIN_FRAC;
            kf_est = x[SAMPLE_W-1:0];
            kf_cov = p_new[COV_W-1:0];
            res.estimate = kf_est;
            res.clamped  = 1'b0;
        end
        expected_results.push_back(res);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: estimate %0d clamped %0b",
                           estimate, clamped);
                    fail_count++;
                end
                else
                begin
                    result_want = expected_results.pop_front();
                    if (estimate !== result_want.estimate)
                    begin
                        $error("estimate mismatch: expected %0d, actual %0d",
                               result_want.estimate, estimate);
                        fail_count++;
                    end
                    if (clamped !== result_want.clamped)
                    begin
                        $error("clamped mismatch: expected %0b, actual %0b",
                               result_want.clamped, clamped);
                        fail_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [SAMPLE_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_PROCESS_NOISE: kf_q     = data[NOISE_W-1:0];
            CFG_MEASURE_NOISE: kf_r     = data[NOISE_W-1:0];
            CFG_SAMPLE_LIMIT:  kf_limit = data;
            default: ;
        endcase
    endtask

    // valid stays high between back-to-back items; wait_idle drops it
    task automatic send_sample(input logic [SAMPLE_W-1:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        measurement <= z;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        kalman_predict(z);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int unsigned sel;
        int unsigned lim;
        int          v;
        sel = $urandom_range(99);
        lim = kf_limit;
        if (sel < 40)
            return SAMPLE_W'($urandom_range(lim, 0));
        if (sel < 70)
        begin
            // track around the current estimate
            v = int'(kf_est) + int'($urandom_range(4096)) - 2048;
            if (v < 0)
                v = 0;
            if (v > int'(SAMPLE_MAX))
                v = int'(SAMPLE_MAX);
            return SAMPLE_W'(v);
        end
        if (sel < 80)
            return kf_limit;
        if (sel < 93 && kf_limit != SAMPLE_MAX)
            return SAMPLE_W'($urandom_range(SAMPLE_MAX, lim + 1));
        return SAMPLE_W'($urandom);
    endfunction

    task automatic randomize_config();
        logic [NOISE_W-1:0]  q;
        logic [NOISE_W-1:0]  r;
        logic [SAMPLE_W-1:0] lim;
        case ($urandom_range(5))
            0:       q = '0;
            1:       q = '1;
            2:       q = NOISE_W'($urandom_range(255));
            default: q = NOISE_W'($urandom);
        endcase
        case ($urandom_range(7))
            0:       r = 16'd1;
            1:       r = '1;
            2:       r = '0;
            default: r = NOISE_W'($urandom);
        endcase
        case ($urandom_range(6))
            0:       lim = '0;
            1:       lim = SAMPLE_MAX;
            2:       lim = LIMIT_RESET[SAMPLE_W-1:0];
            default: lim = SAMPLE_W'($urandom);
        endcase
        write_reg(CFG_PROCESS_NOISE, {4'($urandom), q});
        write_reg(CFG_MEASURE_NOISE, {4'($urandom), r});
        write_reg(CFG_SAMPLE_LIMIT, lim);
        if ($urandom_range(3) == 0)
            write_reg(CFG_UNUSED, SAMPLE_W'($urandom));
    endtask

    task automatic test_reset_config();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_sample(20'd0);
        send_sample(20'd51200);
        send_sample(LIMIT_RESET[SAMPLE_W-1:0]);
        send_sample(LIMIT_RESET[SAMPLE_W-1:0] + 20'd1);
        send_sample(SAMPLE_MAX);
        send_sample(20'd100000);
        wait_idle();
    endtask

    // r = 0 saturates the gain; with q = 0 the covariance collapses to zero
    task automatic test_zero_measure_noise();
        write_reg(CFG_MEASURE_NOISE, 20'd0);
        send_sample(20'd76800);
        wait_idle();
        write_reg(CFG_PROCESS_NOISE, 20'd0);
        send_sample(20'd1000);
        send_sample(20'd500);
        send_sample(20'd0);
        wait_idle();
    endtask

    task automatic test_extremes();
        write_reg(CFG_PROCESS_NOISE, SAMPLE_MAX);
        write_reg(CFG_MEASURE_NOISE, 20'd1);
        write_reg(CFG_SAMPLE_LIMIT, SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(20'd0);
        send_sample(SAMPLE_MAX);
        send_sample(20'd0);
        wait_idle();
        write_reg(CFG_MEASURE_NOISE, 20'h0FFFF);
        send_sample(SAMPLE_MAX);
        send_sample(20'd1);
        wait_idle();
        write_reg(CFG_SAMPLE_LIMIT, 20'd0);
        send_sample(20'd0);
        send_sample(20'd1);
        wait_idle();
        write_reg(CFG_UNUSED, SAMPLE_MAX);
        send_sample(20'd1);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int send_idle[4]  = '{0, 85, 0, 38};
        int recv_stall[4] = '{0, 0, 85, 38};
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = send_idle[ph];
            recv_stall_pct = recv_stall[ph];
            for (int blk = 0; blk < 4; blk++)
            begin
                randomize_config();
                repeat (BLOCK_ITEMS)
                    send_sample(pick_sample());
                wait_idle();
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_config();
        test_zero_measure_noise();
        test_extremes();
        test_random_traffic();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
